### rtl/three_level_page_table_walker_defines.svh
// Assertion macros shared by the walker RTL.
`ifndef THREE_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define THREE_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PTW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("walker assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PTW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("walker assertion failed");

`endif

### rtl/ptw_pkg.sv
package ptw_pkg;

    localparam int VADDR_W = 39;
    localparam int PTE_W   = 64;
    localparam int ADDR_W  = 64;
    localparam int ROOT_W  = 52;
    localparam int PERMS_W = 4;
    localparam int VPN_W   = 9;
    localparam int LEVEL_W = 2;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 136;

    localparam int PTE_V = 0;
    localparam int PTE_R = 1;
    localparam int PTE_W_BIT = 2;
    localparam int PTE_X = 3;
    localparam int PTE_U = 4;

    localparam logic FUNC_TRANSLATE = 1'b0;
    localparam logic FUNC_REPLY     = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef logic [LEVEL_W-1:0] level_t;

    localparam level_t LEVEL_0    = 2'd0;
    localparam level_t LEVEL_1    = 2'd1;
    localparam level_t LEVEL_ROOT = 2'd2;

    function automatic logic [VPN_W-1:0] vpn_at(input logic [VADDR_W-1:0] va,
                                                input level_t level);
        logic [VPN_W-1:0] vpn;
        unique case (level)
            LEVEL_0:    vpn = va[20:12];
            LEVEL_1:    vpn = va[29:21];
            LEVEL_ROOT: vpn = va[38:30];
            default:    vpn = '0;
        endcase
        return vpn;
    endfunction

    function automatic logic [ADDR_W-1:0] page_mask(input level_t level);
        logic [ADDR_W-1:0] mask;
        unique case (level)
            LEVEL_0:    mask = 64'h0000_0000_0000_0fff;
            LEVEL_1:    mask = 64'h0000_0000_001f_ffff;
            LEVEL_ROOT: mask = 64'h0000_0000_3fff_ffff;
            default:    mask = 64'h0000_007f_ffff_ffff;
        endcase
        return mask;
    endfunction

endpackage

### rtl/three_level_page_table_walker.sv
// Sv39-style page table walker. A translate request or an entry reply can be
// accepted in every clock cycle while the output is not stalled by m_tready; each
// request passes an input register and then a result register on its way to the
// output, and the input register lets one more request in while a result
// waits on m_tready.
// A translate request yields a read request for the level-2 entry, each reply
// yields either the next read request or the finished translation, and a
// reply that arrives with no walk in progress is dropped without a result.
// A translate request during a walk abandons that walk and starts over.
// The root page number is written on the cfg channel, which is always ready.
`include "three_level_page_table_walker_defines.svh"

module three_level_page_table_walker
    import ptw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [ROOT_W-1:0]      cfg_data,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: virt_addr[38:0], pte_word[102:39], zero pad.
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: func.
    input  logic                   s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: read_address[63:0], found[64], phys_addr[128:65],
    // perms[132:129], zero pad.
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // Fields from bit 0: kind.
    output logic                   m_tuser
);

    logic [ROOT_W-1:0]  root_reg;

    logic               in_valid_reg;
    logic               in_func_reg;
    logic [VADDR_W-1:0] in_vaddr_reg;
    logic [PTE_W-1:0]   in_pte_reg;

    logic               busy_reg, busy_next;
    level_t             level_reg, level_next;
    logic [VADDR_W-1:0] held_reg, held_next;

    logic               out_valid_reg;
    logic               out_kind_reg, kind_next;
    logic [ADDR_W-1:0]  out_raddr_reg, raddr_next;
    logic               out_found_reg, found_next;
    logic [ADDR_W-1:0]  out_phys_reg, phys_next;
    logic [PERMS_W-1:0] out_perms_reg, perms_next;

    logic               produce;
    logic               out_free;
    logic               advance;
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  mask;
    level_t             down_level;

    assign cfg_ready = 1'b1;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (out_free || !produce);
    assign s_tready = !in_valid_reg || advance;

    assign base       = {in_pte_reg[61:10], 12'b0};
    assign mask       = page_mask(level_reg);
    assign down_level = level_reg - 2'd1;

    always_comb
    begin
        produce    = 1'b1;
        busy_next  = busy_reg;
        level_next = level_reg;
        held_next  = held_reg;
        kind_next  = KIND_READ;
        raddr_next = '0;
        found_next = 1'b0;
        phys_next  = '0;
        perms_next = '0;
        if (in_func_reg == FUNC_TRANSLATE)
        begin
            busy_next  = 1'b1;
            level_next = LEVEL_ROOT;
            held_next  = in_vaddr_reg;
            raddr_next = {root_reg, vpn_at(in_vaddr_reg, LEVEL_ROOT), 3'b0};
        end
        else if (!busy_reg)
        begin
            produce = 1'b0;
        end
        else if (!in_pte_reg[PTE_V] || (in_pte_reg[PTE_W_BIT] && !in_pte_reg[PTE_R]))
        begin
            busy_next = 1'b0;
            kind_next = KIND_DONE;
        end
        else if (in_pte_reg[PTE_R] || in_pte_reg[PTE_X])
        begin
            busy_next  = 1'b0;
            kind_next  = KIND_DONE;
            found_next = 1'b1;
            phys_next  = (base & ~mask) | ({{(ADDR_W-VADDR_W){1'b0}}, held_reg} & mask);
            perms_next = {in_pte_reg[PTE_U], in_pte_reg[PTE_X],
                          in_pte_reg[PTE_W_BIT], in_pte_reg[PTE_R]};
        end
        else if (level_reg == LEVEL_0)
        begin
            busy_next = 1'b0;
            kind_next = KIND_DONE;
        end
        else
        begin
            level_next = down_level;
            raddr_next = {in_pte_reg[61:10], vpn_at(held_reg, down_level), 3'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg      <= '0;
            in_valid_reg  <= 1'b0;
            busy_reg      <= 1'b0;
            level_reg     <= LEVEL_0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                root_reg <= cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                busy_reg  <= busy_next;
                level_reg <= level_next;
                held_reg  <= held_next;
            end
            if (advance && produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg  <= s_tuser;
            in_vaddr_reg <= s_tdata[38:0];
            in_pte_reg   <= s_tdata[102:39];
        end
        if (advance && produce)
        begin
            out_kind_reg  <= kind_next;
            out_raddr_reg <= raddr_next;
            out_found_reg <= found_next;
            out_phys_reg  <= phys_next;
            out_perms_reg <= perms_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {3'b0, out_perms_reg, out_phys_reg, out_found_reg, out_raddr_reg};

    `PTW_ASSERT_IMPL(a_level_in_range, busy_reg, level_reg != 2'd3)
    `PTW_ASSERT_NEXT(a_translate_starts_walk,
        advance && (in_func_reg == FUNC_TRANSLATE),
        busy_reg && (level_reg == LEVEL_ROOT))
    `PTW_ASSERT_NEXT(a_done_ends_walk,
        advance && produce && (kind_next == KIND_DONE), !busy_reg)
    `PTW_ASSERT_IMPL(a_fault_is_clean,
        out_valid_reg && !out_found_reg,
        (out_phys_reg == '0) && (out_perms_reg == '0))

endmodule

### verif/tb_three_level_page_table_walker.sv
module tb_three_level_page_table_walker;
    import ptw_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic [1:0] {
        ENTRY_POINTER,
        ENTRY_LEAF,
        ENTRY_INVALID,
        ENTRY_WRITE_ONLY
    } entry_class_e;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] read_address;
        logic              found;
        logic [ADDR_W-1:0] phys_addr;
        logic [PERMS_W-1:0] perms;
    } walk_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [ROOT_W-1:0]      cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // Fields from bit 0: virt_addr, pte_word, zero pad.
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    // Fields from bit 0: func.
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // Fields from bit 0: read_address, found, phys_addr, perms, zero pad.
    logic [OUT_TDATA_W-1:0] m_tdata;
    // Fields from bit 0: kind.
    logic                   m_tuser;

    walk_result_t       walk_results[$];
    logic [ROOT_W-1:0]  root_ppn = '0;
    logic               walk_active = 1'b0;
    level_t             walk_lvl = LEVEL_0;
    logic [VADDR_W-1:0] walk_va = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int result_count = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stuck_cycles = 0;

    three_level_page_table_walker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_OFF_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] want,
                                   input logic [ADDR_W-1:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin
        walk_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (walk_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, got kind %0b data %h",
                         $time, m_tuser, m_tdata);
            end
            else
            begin
                want = walk_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", ADDR_W'(want.kind), ADDR_W'(m_tuser));
                if (m_tdata[63:0] !== want.read_address)
                    report_mismatch("read_address", want.read_address, m_tdata[63:0]);
                if (m_tdata[64] !== want.found)
                    report_mismatch("found", ADDR_W'(want.found), ADDR_W'(m_tdata[64]));
                if (m_tdata[128:65] !== want.phys_addr)
                    report_mismatch("phys_addr", want.phys_addr, m_tdata[128:65]);
                if (m_tdata[132:129] !== want.perms)
                    report_mismatch("perms", ADDR_W'(want.perms),
                                    ADDR_W'(m_tdata[132:129]));
            end
        end
    end

    task automatic predict_walk_step(input logic func, input logic [VADDR_W-1:0] va,
                                     input logic [PTE_W-1:0] pte);
        walk_result_t       res;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  mask;
        logic [VPN_W-1:0]   vpn;
        res = '0;
        base = {pte[61:10], 12'h000};
        if (func == FUNC_TRANSLATE)
        begin
            walk_va = va;
            walk_lvl = LEVEL_ROOT;
            walk_active = 1'b1;
            vpn = VPN_W'(walk_va >> (12 + 9 * walk_lvl));
            res.kind = KIND_READ;
            res.read_address = {root_ppn, 12'h000} + (ADDR_W'(vpn) << 3);
        end
        else if (!walk_active)
        begin
            return;
        end
        else if (!pte[PTE_V] || (pte[PTE_W_BIT] && !pte[PTE_R]))
        begin
            walk_active = 1'b0;
            res.kind = KIND_DONE;
        end
        else if (pte[PTE_R] || pte[PTE_X])
        begin
            mask = (64'd1 << (12 + 9 * walk_lvl)) - 64'd1;
            walk_active = 1'b0;
            res.kind = KIND_DONE;
            res.found = 1'b1;
            res.phys_addr = (base & ~mask) | (ADDR_W'(walk_va) & mask);
            res.perms = {pte[PTE_U], pte[PTE_X], pte[PTE_W_BIT], pte[PTE_R]};
        end
        else if (walk_lvl == LEVEL_0)
        begin
            walk_active = 1'b0;
            res.kind = KIND_DONE;
        end
        else
        begin
            walk_lvl = walk_lvl - 2'd1;
            vpn = VPN_W'(walk_va >> (12 + 9 * walk_lvl));
            res.kind = KIND_READ;
            res.read_address = base + (ADDR_W'(vpn) << 3);
        end
        walk_results.push_back(res);
        result_count++;
    endtask

    function automatic logic [PTE_W-1:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [VADDR_W-1:0] random_va();
        return VADDR_W'(random_word());
    endfunction

    function automatic logic [PTE_W-1:0] make_pte(input entry_class_e cls);
        logic [PTE_W-1:0] w;
        logic [2:0]       rwx;
        w = random_word();
        case (cls)
            ENTRY_POINTER:
            begin
                w[PTE_V] = 1'b1;
                w[PTE_R] = 1'b0;
                w[PTE_W_BIT] = 1'b0;
                w[PTE_X] = 1'b0;
            end
            ENTRY_LEAF:
            begin
                rwx = 3'($urandom_range(1, 7));
                if (rwx[1] && !rwx[0])
                    rwx[0] = 1'b1;
                w[PTE_V] = 1'b1;
                w[PTE_R] = rwx[0];
                w[PTE_W_BIT] = rwx[1];
                w[PTE_X] = rwx[2];
            end
            ENTRY_INVALID:
            begin
                w[PTE_V] = 1'b0;
            end
            default:
            begin
                w[PTE_V] = 1'b1;
                w[PTE_R] = 1'b0;
                w[PTE_W_BIT] = 1'b1;
            end
        endcase
        return w;
    endfunction

    task automatic send_request(input logic func, input logic [VADDR_W-1:0] va,
                                input logic [PTE_W-1:0] pte);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {{(IN_TDATA_W - PTE_W - VADDR_W){1'b0}}, pte, va};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_walk_step(func, va, pte);
    endtask

    task automatic send_translate(input logic [VADDR_W-1:0] va);
        send_request(FUNC_TRANSLATE, va, random_word());
    endtask

    task automatic send_reply(input logic [PTE_W-1:0] pte);
        send_request(FUNC_REPLY, random_va(), pte);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (walk_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_root(input logic [ROOT_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        root_ppn = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_walk();
        int           roll;
        entry_class_e cls;
        if ($urandom_range(0, 99) < 8)
        begin
            send_reply(random_word());
            return;
        end
        send_translate(random_va());
        for (int depth = 0; depth < 3; depth++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                send_translate(random_va());
                return;
            end
            cls = (roll < 50) ? ENTRY_POINTER :
                  (roll < 85) ? ENTRY_LEAF :
                  (roll < 93) ? ENTRY_INVALID : ENTRY_WRITE_ONLY;
            send_reply(make_pte(cls));
            if (cls != ENTRY_POINTER)
                return;
        end
    endtask

    task automatic test_root_settings();
        write_root('0);
        send_translate('0);
        send_reply('0);
        write_root('1);
        send_translate('1);
        send_reply(make_pte(ENTRY_WRITE_ONLY));
        write_root(ROOT_W'(random_word()));
    endtask

    task automatic test_leaf_levels();
        send_translate('1);
        send_reply('1);
        send_translate(random_va());
        send_reply(make_pte(ENTRY_POINTER));
        send_reply(make_pte(ENTRY_LEAF));
        send_translate(random_va());
        send_reply(make_pte(ENTRY_POINTER));
        send_reply(make_pte(ENTRY_POINTER));
        send_reply(make_pte(ENTRY_LEAF));
        send_translate(random_va());
        send_reply(make_pte(ENTRY_POINTER));
        send_reply(make_pte(ENTRY_POINTER));
        send_reply(make_pte(ENTRY_POINTER));
    endtask

    task automatic test_faults();
        send_translate(random_va());
        send_reply(make_pte(ENTRY_INVALID));
        send_translate(random_va());
        send_reply(make_pte(ENTRY_POINTER));
        send_reply(make_pte(ENTRY_WRITE_ONLY));
    endtask

    task automatic test_special_cases();
        logic [PTE_W-1:0] exec_only;
        exec_only = make_pte(ENTRY_LEAF);
        exec_only[PTE_R] = 1'b0;
        exec_only[PTE_W_BIT] = 1'b0;
        exec_only[PTE_X] = 1'b1;
        settle();
        send_reply('1);
        send_translate(random_va());
        send_reply(make_pte(ENTRY_POINTER));
        send_translate(random_va());
        send_reply(exec_only);
    endtask

    task automatic test_random_walks(input int sender_pct, input int receiver_pct,
                                     input int result_target);
        int start;
        write_root(ROOT_W'(random_word()));
        send_idle_pct = sender_pct;
        recv_stall_pct = receiver_pct;
        start = result_count;
        while (result_count - start < result_target)
            random_walk();
    endtask

    task automatic test_backpressure();
        settle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_token <= hold_token + 1;
        repeat (12) random_walk();
        settle();
        repeat (6) random_walk();
    endtask

    initial
    begin
        send_idle_pct = 10;
        recv_stall_pct = 81;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_root_settings();
        test_leaf_levels();
        test_faults();
        test_special_cases();
        test_random_walks(10, 81, 125);
        test_random_walks(81, 10, 125);
        test_random_walks(0, 0, 125);
        test_backpressure();
        settle();
        if (mismatch_count == 0 && walk_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
